// File: rtl/core/mpqs_pkg.sv
`default_nettype none

package mpqs_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;

  localparam logic OP_INSERT = 1'b0;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StScan   = 4'b0010,
    StFill   = 4'b0100,
    StFinish = 4'b1000
  } state_e;

endpackage

`default_nettype wire

// File: rtl/core/min_priority_queue_scan.sv
// Min-priority queue over an unsorted key RAM, one request at a time. An insert
// appends the key after the stored entries (or reports full) and returns its
// result through StFinish into the output register. An extract-min reads every
// stored entry through the single RAM read port, one per cycle, keeps the first
// smallest key, then writes the last entry into the freed slot (StScan, StFill,
// StFinish). An extract on an empty queue goes straight to StFinish, with status
// empty. The result sits in an output register; the next request is accepted as
// soon as the result is loaded there.
`default_nettype none

module min_priority_queue_scan #(
  parameter int unsigned Capacity = mpqs_pkg::CAPACITY,
  localparam int unsigned CntW = $clog2(Capacity + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          opcode_i,
  input  wire logic [mpqs_pkg::VALUE_W-1:0]  value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [mpqs_pkg::VALUE_W-1:0]  min_value_o,
  output logic      [mpqs_pkg::STATUS_W-1:0] status_o,
  output logic      [CntW-1:0]               occupancy_o
);

  import mpqs_pkg::*;

  localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1;

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     issue_q, issue_d;
  logic                rdv_q, rdv_d;
  logic [AddrW-1:0]    tag_q, tag_d;
  logic [VALUE_W-1:0]  res_min_q, res_min_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;

  logic                out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]  min_value_q, min_value_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [CntW-1:0]     occupancy_q, occupancy_d;

  logic                ram_we, ram_re;
  logic [AddrW-1:0]    ram_waddr;
  logic [VALUE_W-1:0]  ram_wdata, ram_rdata;

  logic                scan_clear;
  logic [VALUE_W-1:0]  scan_best, scan_last;
  logic [AddrW-1:0]    scan_pos;

  logic                is_full, is_empty, out_free;
  logic [CntW-1:0]     count_m1;
  logic [AddrW-1:0]    last_idx;

  assign is_full  = (count_q == CntW'(Capacity));
  assign is_empty = (count_q == '0);
  assign count_m1 = count_q - CntW'(1);
  assign last_idx = count_m1[AddrW-1:0];
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    issue_d      = issue_q;
    rdv_d        = 1'b0;
    tag_d        = tag_q;
    res_min_d    = res_min_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[AddrW-1:0];
    ram_wdata    = value_i;
    ram_re       = 1'b0;
    scan_clear   = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;
    min_value_d  = min_value_q;
    status_d     = status_q;
    occupancy_d  = occupancy_q;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          res_min_d = '0;
          if (opcode_i == OP_INSERT) begin
            state_d = StFinish;
            if (is_full) begin
              res_status_d = STATUS_FULL;
            end else begin
              ram_we       = 1'b1;
              count_d      = count_q + CntW'(1);
              res_status_d = STATUS_OK;
            end
          end else if (is_empty) begin
            res_status_d = STATUS_EMPTY;
            state_d      = StFinish;
          end else begin
            issue_d    = '0;
            scan_clear = 1'b1;
            state_d    = StScan;
          end
        end
      end
      StScan: begin
        if (issue_q < count_q) begin
          ram_re  = 1'b1;
          issue_d = issue_q + CntW'(1);
          rdv_d   = 1'b1;
          tag_d   = issue_q[AddrW-1:0];
        end
        if (rdv_q && (tag_q == last_idx)) begin
          state_d = StFill;
        end
      end
      StFill: begin
        // last entry moves into the hole; harmless when they coincide
        ram_we       = 1'b1;
        ram_waddr    = scan_pos;
        ram_wdata    = scan_last;
        count_d      = count_m1;
        res_min_d    = scan_best;
        res_status_d = STATUS_OK;
        state_d      = StFinish;
      end
      StFinish: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          min_value_d = res_min_q;
          status_d    = res_status_q;
          occupancy_d = count_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rdv_q       <= rdv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    issue_q      <= issue_d;
    tag_q        <= tag_d;
    res_min_q    <= res_min_d;
    res_status_q <= res_status_d;
    min_value_q  <= min_value_d;
    status_q     <= status_d;
    occupancy_q  <= occupancy_d;
  end

  mpqs_ram #(
    .Width(VALUE_W),
    .Depth(Capacity)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(issue_q[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  mpqs_scan #(
    .AddrW(AddrW)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clear_i(scan_clear),
    .valid_i(rdv_q),
    .data_i (ram_rdata),
    .index_i(tag_q),
    .best_o (scan_best),
    .pos_o  (scan_pos),
    .last_o (scan_last)
  );

  assign out_valid_o = out_valid_q;
  assign min_value_o = min_value_q;
  assign status_o    = status_q;
  assign occupancy_o = occupancy_q;

endmodule

`default_nettype wire

// File: rtl/core/mpqs_ram.sv
`default_nettype none

module mpqs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/mpqs_scan.sv
`default_nettype none

module mpqs_scan #(
  parameter int unsigned AddrW = 10
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         clear_i,
  input  wire logic                         valid_i,
  input  wire logic [mpqs_pkg::VALUE_W-1:0] data_i,
  input  wire logic [AddrW-1:0]             index_i,
  output logic      [mpqs_pkg::VALUE_W-1:0] best_o,
  output logic      [AddrW-1:0]             pos_o,
  output logic      [mpqs_pkg::VALUE_W-1:0] last_o
);

  import mpqs_pkg::*;

  logic               has_q, has_d;
  logic [VALUE_W-1:0] best_q, best_d;
  logic [AddrW-1:0]   pos_q, pos_d;
  logic [VALUE_W-1:0] last_q, last_d;
  logic               take;

  // strict less-than keeps the lowest position among equal keys
  assign take = valid_i && (!has_q || (data_i < best_q));

  always_comb begin
    has_d  = has_q;
    best_d = best_q;
    pos_d  = pos_q;
    last_d = last_q;
    if (clear_i) begin
      has_d = 1'b0;
    end else begin
      if (valid_i) begin
        has_d  = 1'b1;
        last_d = data_i;
      end
      if (take) begin
        best_d = data_i;
        pos_d  = index_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_q <= 1'b0;
    end else begin
      has_q <= has_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    pos_q  <= pos_d;
    last_q <= last_d;
  end

  assign best_o = best_q;
  assign pos_o  = pos_q;
  assign last_o = last_q;

endmodule

`default_nettype wire
